@@ rtl/core/pwcd_pkg.sv @@
`timescale 1ns / 1ps

package pwcd_pkg;

   // Fixed field and register widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int CUTOFF_W    = 24;
   localparam int SPLIT_W     = 21;
   localparam int LIMIT_W     = 25;   // ten split periods of the widest split value
   localparam int BYTE_W      = 8;
   localparam int BIT_COUNT_W = 4;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_FIELD_W = 1 + BYTE_W + 1;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_CUTOFF  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_SPLIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_ENABLE = 2'd2;

   // Reset values
   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 24'd4000;
   localparam logic [SPLIT_W-1:0]  SPLIT_RESET  = 21'd1875;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 25'd18750;

   typedef struct packed {
      logic [CUTOFF_W-1:0] bit_cutoff;
      logic [SPLIT_W-1:0]  bit_split;
      logic [LIMIT_W-1:0]  hold_limit;   // bit_split * 10
      logic                hold_enable;
   } cfg_type;

   typedef struct packed {
      logic              command_valid;
      logic [BYTE_W-1:0] command_byte;
      logic              hold_display;
   } result_type;

endpackage

@@ rtl/core/pwcd_csr.sv @@
`timescale 1ns / 1ps

module pwcd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pwcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pwcd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pwcd_pkg::cfg_type                  cfg,
   output logic                               hold_clear
);

   logic [pwcd_pkg::CUTOFF_W-1:0] cutoff_ff, cutoff_in;
   logic [pwcd_pkg::SPLIT_W-1:0]  split_ff, split_in;
   logic [pwcd_pkg::LIMIT_W-1:0]  limit_ff, limit_in;
   logic                          hold_en_ff, hold_en_in;
   logic [pwcd_pkg::LIMIT_W-1:0]  split_ext;

   // limit = split * 10, worked out once per write
   assign split_ext = pwcd_pkg::LIMIT_W'(csr_wdata[pwcd_pkg::SPLIT_W-1:0]);

   always_comb begin
      cutoff_in  = cutoff_ff;
      split_in   = split_ff;
      limit_in   = limit_ff;
      hold_en_in = hold_en_ff;
      hold_clear = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            pwcd_pkg::REG_BIT_CUTOFF: begin
               cutoff_in = csr_wdata[pwcd_pkg::CUTOFF_W-1:0];
            end
            pwcd_pkg::REG_BIT_SPLIT: begin
               split_in = csr_wdata[pwcd_pkg::SPLIT_W-1:0];
               limit_in = (split_ext << 3) + (split_ext << 1);
            end
            pwcd_pkg::REG_HOLD_ENABLE: begin
               hold_en_in = csr_wdata[0];
               hold_clear = ~csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff  <= pwcd_pkg::CUTOFF_RESET;
         split_ff   <= pwcd_pkg::SPLIT_RESET;
         limit_ff   <= pwcd_pkg::LIMIT_RESET;
         hold_en_ff <= 1'b1;
      end else begin
         cutoff_ff  <= cutoff_in;
         split_ff   <= split_in;
         limit_ff   <= limit_in;
         hold_en_ff <= hold_en_in;
      end
   end

   assign cfg.bit_cutoff  = cutoff_ff;
   assign cfg.bit_split   = split_ff;
   assign cfg.hold_limit  = limit_ff;
   assign cfg.hold_enable = hold_en_ff;

endmodule

@@ rtl/core/pwcd_decode.sv @@
`timescale 1ns / 1ps

module pwcd_decode #(
   parameter int COUNT_WIDTH      = 24,
   parameter int BITS_PER_COMMAND = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  line_level,
   input  pwcd_pkg::cfg_type     cfg,
   input  logic                  hold_clear,
   output pwcd_pkg::result_type  result
);

   localparam int CMP_W = (COUNT_WIDTH > pwcd_pkg::LIMIT_W) ? COUNT_WIDTH : pwcd_pkg::LIMIT_W;

   logic                               prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0]             tsc_ff, tsc_in, tsc_inc;
   logic [COUNT_WIDTH-1:0]             tsp_ff, tsp_in, tsp_inc;
   logic [pwcd_pkg::BYTE_W-1:0]        shift_ff, shift_in, shift_new;
   logic [pwcd_pkg::BIT_COUNT_W-1:0]   count_ff, count_in, count_new;
   logic                               hold_ff, hold_in, hold_pulse;
   logic [pwcd_pkg::BYTE_W-1:0]        last_ff, last_in;
   logic                               rise, is_bit, bit_val, done, timeout;
   logic [CMP_W-1:0]                   period_x, tsp_x, cutoff_x, split_x, limit_x;

   // saturating tick counters
   assign tsc_inc = (&tsc_ff) ? tsc_ff : tsc_ff + 1'b1;
   assign tsp_inc = (&tsp_ff) ? tsp_ff : tsp_ff + 1'b1;

   assign period_x = CMP_W'(tsc_inc);
   assign cutoff_x = CMP_W'(cfg.bit_cutoff);
   assign split_x  = CMP_W'(cfg.bit_split);
   assign limit_x  = CMP_W'(cfg.hold_limit);

   assign rise      = ~prev_ff & line_level;
   assign is_bit    = period_x < cutoff_x;
   assign bit_val   = period_x < split_x;
   assign shift_new = {shift_ff[pwcd_pkg::BYTE_W-2:0], bit_val};
   assign count_new = count_ff + 1'b1;
   assign done      = rise & is_bit &
                      (count_new >= pwcd_pkg::BIT_COUNT_W'(BITS_PER_COMMAND));

   always_comb begin
      hold_pulse = hold_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      tsp_in     = tsp_inc;
      if (rise) begin
         tsp_in = '0;
         if (is_bit) begin
            if (done) begin
               hold_pulse = 1'b0;
               shift_in   = '0;
               count_in   = '0;
            end else begin
               shift_in = shift_new;
               count_in = count_new;
               if (cfg.hold_enable) hold_pulse = 1'b1;
            end
         end else begin
            // long pulse: preamble if under ten split periods
            shift_in = '0;
            count_in = '0;
            if (cfg.hold_enable && (period_x < limit_x)) hold_pulse = 1'b1;
         end
      end
      tsp_x   = CMP_W'(tsp_in);
      timeout = hold_pulse & (tsp_x > limit_x);
      hold_in = hold_pulse;
      if (timeout) begin
         hold_in  = 1'b0;
         shift_in = '0;
         count_in = '0;
      end
   end

   assign tsc_in  = (line_level != prev_ff) ? '0 : tsc_inc;
   assign prev_in = line_level;
   assign last_in = done ? shift_new : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b1;
         tsc_ff   <= '0;
         tsp_ff   <= '0;
         shift_ff <= '0;
         count_ff <= '0;
         hold_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (advance) begin
         prev_ff  <= prev_in;
         tsc_ff   <= tsc_in;
         tsp_ff   <= tsp_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         hold_ff  <= hold_in;
         last_ff  <= last_in;
      end else if (hold_clear) begin
         hold_ff <= 1'b0;
      end
   end

   assign result.command_valid = done;
   assign result.command_byte  = last_in;
   assign result.hold_display  = hold_in;

endmodule

@@ rtl/core/pulse_width_command_decoder.sv @@
`timescale 1ns / 1ps
// Pulse-width command decoder.
// req_ carries one line sample per microsecond tick (tdata bit 0, idle high).
// Each low pulse is timed to its rising edge; short pulses shift in command
// bits MSB first, and a full command is reported with command_valid set.
// rsp_ returns exactly one transaction per req_ transaction, in order, with
// command_valid, the last command byte and the hold-display flag.
// csr_ is a write-only register port: index 0 bit cutoff, 1 bit split,
// 2 hold enable. Writes take effect on the next edge; write only when idle.
// A sample accepted into the input register moves through the state update
// into the result register once that is free. Throughput: one transaction
// per cycle while rsp_ is not stalled; the state update is combinational.
// A stalled rsp_ side holds its result; the input register still takes one
// more sample, after which req_tready drops until the result is taken.
// Reset (synchronous, active high) restores default registers, clears the
// timers, the collected bits, the hold flag and the last command, and
// empties both registers.
module pulse_width_command_decoder #(
   parameter int COUNT_WIDTH      = 24,
   parameter int BITS_PER_COMMAND = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pwcd_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] line_level
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] command_valid, [8:1] command_byte, [9] hold_display
   output logic [pwcd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [pwcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pwcd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pwcd_pkg::cfg_type    cfg;
   pwcd_pkg::result_type result;
   logic                 hold_clear;

   logic in_valid_ff, in_valid_in;
   logic level_ff, level_in;
   logic out_valid_ff, out_valid_in;
   pwcd_pkg::result_type out_data_ff, out_data_in;
   logic out_free, advance, req_take;

   // result register is free when empty or being drained this cycle
   assign out_free   = ~out_valid_ff | rsp_tready;
   assign advance    = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;
   assign req_take   = req_tvalid & req_tready;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign level_in     = req_take ? req_tdata[0] : level_ff;
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);
   assign out_data_in  = advance ? result : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      out_data_ff <= out_data_in;
   end

   pwcd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .hold_clear (hold_clear)
   );

   pwcd_decode #(
      .COUNT_WIDTH      (COUNT_WIDTH),
      .BITS_PER_COMMAND (BITS_PER_COMMAND)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .line_level (level_ff),
      .cfg        (cfg),
      .hold_clear (hold_clear),
      .result     (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pwcd_pkg::RSP_DATA_W'({out_data_ff.hold_display,
                                               out_data_ff.command_byte,
                                               out_data_ff.command_valid});

`ifndef SYNTHESIS
   // a completed command always drops the hold flag
   a_valid_drops_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> !rsp_tdata[9])
      else $error("command reported with hold flag set");

   // input side only stalls when both registers are full and the output is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without cause");

   // a sample moved into the decoder always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost after advance");
`endif

endmodule
